// File: hw/rtl/ple_pkg.sv
// package for the positional list engine: sizes, codes, state and command types
// used by ple_ctrl, ple_dp and the top level; depends on nothing
package ple_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ACT_W      = 3;
  localparam int POS_W      = 9;
  localparam int VAL_W      = 32;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SH,
    S_INS_WR,
    S_DEL_CAP,
    S_DEL_SH,
    S_GET_CAP,
    S_LOC,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LOAD_AT,
    PTR_LOAD_TOP,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_SHIFT_DN,
    WR_VALUE
  } wr_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_INIT,
    RES_READ,
    RES_FOUND
  } res_op_e;

  typedef struct packed {
    logic    latch;
    ptr_op_e ptr_op;
    logic    rd_en;
    wr_op_e  wr_op;
    res_op_e res_op;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    act_e action;
    logic full;
    logic ins_ok;
    logic acc_ok;
    logic ptr_at;
    logic more;
    logic match;
    logic out_busy;
  } sts_t;

endpackage

// File: hw/rtl/ple_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ple_ctrl.sv
// controller state machine of the positional list engine
// depends on ple_pkg; drives commands to ple_dp and reads its status
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o
);

  ple_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    cmd_o.latch    = 1'b0;
    cmd_o.ptr_op   = ple_pkg::PTR_HOLD;
    cmd_o.rd_en    = 1'b0;
    cmd_o.wr_op    = ple_pkg::WR_NONE;
    cmd_o.res_op   = ple_pkg::RES_NONE;
    cmd_o.publish  = 1'b0;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ple_pkg::S_DISPATCH;
        end
      end
      ple_pkg::S_DISPATCH: begin
        cmd_o.res_op = ple_pkg::RES_INIT;
        state_d      = ple_pkg::S_DONE;
        unique case (sts_i.action)
          ple_pkg::ACT_INSERT: begin
            if (!sts_i.full && sts_i.ins_ok) begin
              if (sts_i.acc_ok) begin
                cmd_o.ptr_op = ple_pkg::PTR_LOAD_TOP;
                cmd_o.rd_en  = 1'b1;
                state_d      = ple_pkg::S_INS_SH;
              end else begin
                state_d = ple_pkg::S_INS_WR;
              end
            end
          end
          ple_pkg::ACT_DELETE: begin
            if (sts_i.acc_ok) begin
              cmd_o.ptr_op = ple_pkg::PTR_LOAD_AT;
              cmd_o.rd_en  = 1'b1;
              state_d      = ple_pkg::S_DEL_CAP;
            end
          end
          ple_pkg::ACT_GET: begin
            if (sts_i.acc_ok) begin
              cmd_o.ptr_op = ple_pkg::PTR_LOAD_AT;
              cmd_o.rd_en  = 1'b1;
              state_d      = ple_pkg::S_GET_CAP;
            end
          end
          ple_pkg::ACT_LOCATE: begin
            if (sts_i.more) begin
              cmd_o.ptr_op = ple_pkg::PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = ple_pkg::S_LOC;
            end
          end
          default: begin
            state_d = ple_pkg::S_DONE;
          end
        endcase
      end
      ple_pkg::S_INS_SH: begin
        cmd_o.wr_op = ple_pkg::WR_SHIFT_UP;
        if (sts_i.ptr_at) begin
          state_d = ple_pkg::S_INS_WR;
        end else begin
          cmd_o.ptr_op = ple_pkg::PTR_DEC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ple_pkg::S_INS_WR: begin
        cmd_o.wr_op = ple_pkg::WR_VALUE;
        state_d     = ple_pkg::S_DONE;
      end
      ple_pkg::S_DEL_CAP: begin
        cmd_o.res_op = ple_pkg::RES_READ;
        if (sts_i.more) begin
          cmd_o.ptr_op = ple_pkg::PTR_INC;
          cmd_o.rd_en  = 1'b1;
          state_d      = ple_pkg::S_DEL_SH;
        end else begin
          state_d = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_DEL_SH: begin
        cmd_o.wr_op = ple_pkg::WR_SHIFT_DN;
        if (sts_i.more) begin
          cmd_o.ptr_op = ple_pkg::PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end else begin
          state_d = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_GET_CAP: begin
        cmd_o.res_op = ple_pkg::RES_READ;
        state_d      = ple_pkg::S_DONE;
      end
      ple_pkg::S_LOC: begin
        if (sts_i.match) begin
          cmd_o.res_op = ple_pkg::RES_FOUND;
          state_d      = ple_pkg::S_DONE;
        end else if (sts_i.more) begin
          cmd_o.ptr_op = ple_pkg::PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end else begin
          state_d = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/ple_dp.sv
// datapath of the positional list engine: element store, count, walk pointer,
// result and output registers; depends on ple_pkg and ple_ram
module ple_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ple_pkg::cmd_t                       cmd_i,
  output ple_pkg::sts_t                       sts_o,
  input  logic [ple_pkg::ACT_W-1:0]           action_i,
  input  logic [ple_pkg::POS_W-1:0]           position_i,
  input  logic signed [ple_pkg::VAL_W-1:0]    value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [ple_pkg::VAL_W-1:0]    read_value_o,
  output logic [ple_pkg::POS_W-1:0]           found_position_o,
  output logic [ple_pkg::POS_W-1:0]           list_length_o,
  output logic                                is_empty_o
);

  localparam int AW = ple_pkg::ADDR_W;
  localparam int CW = ple_pkg::CNT_W;
  localparam int MW = ple_pkg::CMP_W;
  localparam int DW = ple_pkg::DATA_WIDTH;
  localparam int PW = ple_pkg::POS_W;

  ple_pkg::act_e      act_q;
  logic [PW-1:0]      pos_q;
  logic [DW-1:0]      val_q;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  ple_pkg::status_e   res_status_q;
  logic [DW-1:0]      res_rd_q;
  logic [PW-1:0]      res_found_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [ple_pkg::VAL_W-1:0] out_rd_q;
  logic [PW-1:0]      out_found_q;
  logic [PW-1:0]      out_len_q;
  logic               out_empty_q;

  logic [AW-1:0]      at;
  logic [MW-1:0]      pos_x, cnt_x, ptr_x;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [DW-1:0]      wdata;
  logic [DW-1:0]      rdata;

  assign at    = AW'(pos_q - PW'(1));
  assign pos_x = MW'(pos_q);
  assign cnt_x = MW'(count_q);
  assign ptr_x = MW'(ptr_q);

  assign sts_o.action   = act_q;
  assign sts_o.full     = (count_q == CW'(ple_pkg::CAPACITY));
  assign sts_o.ins_ok   = (pos_q != '0) && (pos_x <= cnt_x + MW'(1));
  assign sts_o.acc_ok   = (pos_q != '0) && (pos_x <= cnt_x);
  assign sts_o.ptr_at   = (ptr_q == at);
  assign sts_o.more     = (cmd_i.res_op == ple_pkg::RES_INIT) ? (count_q != '0)
                                                               : (ptr_x + MW'(1) < cnt_x);
  assign sts_o.match    = (rdata == val_q);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= ple_pkg::act_e'(action_i);
      pos_q <= position_i;
      val_q <= DW'(value_i);
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      ple_pkg::PTR_LOAD_AT:  ptr_d = at;
      ple_pkg::PTR_LOAD_TOP: ptr_d = AW'(count_q - CW'(1));
      ple_pkg::PTR_ZERO:     ptr_d = '0;
      ple_pkg::PTR_INC:      ptr_d = ptr_q + AW'(1);
      ple_pkg::PTR_DEC:      ptr_d = ptr_q - AW'(1);
      default:               ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = at;
    wdata = rdata;
    case (cmd_i.wr_op)
      ple_pkg::WR_SHIFT_UP: waddr = ptr_q + AW'(1);
      ple_pkg::WR_SHIFT_DN: waddr = ptr_q - AW'(1);
      ple_pkg::WR_VALUE:    wdata = val_q;
      default:              we    = 1'b0;
    endcase
  end

  ple_ram #(
    .WIDTH(DW),
    .DEPTH(ple_pkg::CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ptr_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      ple_pkg::RES_INIT: begin
        res_rd_q    <= '0;
        res_found_q <= '0;
        case (act_q) inside
          ple_pkg::ACT_INSERT: begin
            if (sts_o.full) begin
              res_status_q <= ple_pkg::ST_FULL;
            end else if (!sts_o.ins_ok) begin
              res_status_q <= ple_pkg::ST_RANGE;
            end else begin
              res_status_q <= ple_pkg::ST_OK;
            end
          end
          ple_pkg::ACT_DELETE, ple_pkg::ACT_GET: begin
            res_status_q <= sts_o.acc_ok ? ple_pkg::ST_OK : ple_pkg::ST_RANGE;
          end
          ple_pkg::ACT_LOCATE: res_status_q <= ple_pkg::ST_NOTFOUND;
          default:             res_status_q <= ple_pkg::ST_OK;
        endcase
      end
      ple_pkg::RES_READ: res_rd_q <= rdata;
      ple_pkg::RES_FOUND: begin
        res_status_q <= ple_pkg::ST_OK;
        res_found_q  <= PW'(ptr_q) + PW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (res_status_q == ple_pkg::ST_OK) begin
      case (act_q)
        ple_pkg::ACT_INSERT: count_d = count_q + CW'(1);
        ple_pkg::ACT_DELETE: count_d = count_q - CW'(1);
        ple_pkg::ACT_CLEAR:  count_d = '0;
        default:             count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.publish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_rd_q     <= ple_pkg::VAL_W'($signed(res_rd_q));
      out_found_q  <= res_found_q;
      out_len_q    <= PW'(count_d);
      out_empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign read_value_o     = $signed(out_rd_q);
  assign found_position_o = out_found_q;
  assign list_length_o    = out_len_q;
  assign is_empty_o       = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ple_pkg::CAPACITY))
    else $error("element count above capacity");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !(out_valid_q && out_stall_i))
    else $error("result published over a waiting word");

  a_no_write_on_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (cmd_i.wr_op == ple_pkg::WR_NONE))
    else $error("store written while publishing");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_op == ple_pkg::WR_SHIFT_UP) |-> (ptr_x < cnt_x))
    else $error("insert shift beyond list end");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_len_q == '0)))
    else $error("empty flag disagrees with length");

endmodule

// File: hw/rtl/positional_list_engine.sv
// Ordered list of up to 256 signed 32-bit values kept in one registered-read
// ram; positions count from 1. Each accepted word runs on its own: the
// controller walks the ram one element per cycle. Insert shifts the elements
// from position p to the end up by one, starting at the end, then writes the
// value at p; delete reads the element at p and shifts the later ones down;
// locate reads from the first element until a match or the end of the list.
// A result is published only once any earlier result stalled at the output
// has been taken. A new word is taken once the previous one has reached the
// output register, even while that result still waits. No clearing pass is
// needed after reset.
// Depends on ple_pkg, ple_ctrl, ple_dp and ple_ram.
module positional_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ple_pkg::ACT_W-1:0]         action_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  input  logic signed [ple_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [ple_pkg::VAL_W-1:0]  read_value_o,
  output logic [ple_pkg::POS_W-1:0]         found_position_o,
  output logic [ple_pkg::POS_W-1:0]         list_length_o,
  output logic                              is_empty_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ple_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .list_length_o   (list_length_o),
    .is_empty_o      (is_empty_o)
  );

endmodule
